>>> src/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  // Fixed field widths
  localparam int WORD_W        = 16;  // every matrix entry and quaternion component
  localparam int DIFF_W        = 17;  // sum or difference of two entries
  localparam int ARG_W         = 18;  // sum of three entries
  localparam int FRAC_BITS_DEF = 14;

  // Which component the root feeds
  typedef enum logic [1:0] {
    SEL_TRACE,
    SEL_X,
    SEL_Y,
    SEL_Z
  } sel_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] m00;
    logic signed [WORD_W-1:0] m01;
    logic signed [WORD_W-1:0] m02;
    logic signed [WORD_W-1:0] m10;
    logic signed [WORD_W-1:0] m11;
    logic signed [WORD_W-1:0] m12;
    logic signed [WORD_W-1:0] m20;
    logic signed [WORD_W-1:0] m21;
    logic signed [WORD_W-1:0] m22;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] qx;
    logic signed [WORD_W-1:0] qy;
    logic signed [WORD_W-1:0] qz;
    logic signed [WORD_W-1:0] qw;
  } out_item_t;

endpackage

`default_nettype wire

>>> src/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Two pipeline stages: pivot selection, root argument and off-diagonal terms,
// then magnitudes and the fixed-point radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front import rmq_pkg::*; #(
  parameter int F  = FRAC_BITS_DEF,
  parameter int AW = 19,
  parameter int NW = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [NW-1:0]               out_rad,
  output logic [2:0][DIFF_W-1:0]      out_mag,
  output logic [2:0]                  out_sgn,
  output sel_t                        out_sel
);

  localparam logic signed [AW-1:0] ONE_A = AW'(1) << F;

  // Stage 1 registers
  logic                          v1_r;
  logic signed [ARG_W-1:0]       arg_r, arg_nxt;
  logic signed [DIFF_W-1:0]      d_r [3];
  logic signed [DIFF_W-1:0]      d_nxt [3];
  sel_t                          sel1_r, sel1_nxt;
  // Stage 2 registers
  logic                          v2_r;
  logic [NW-1:0]                 rad_r, rad_nxt;
  logic [2:0][DIFF_W-1:0]        mag_r, mag_nxt;
  logic [2:0]                    sgn_r, sgn_nxt;
  sel_t                          sel2_r;

  logic rdy1, rdy2;
  logic signed [ARG_W-1:0]  tr;
  logic signed [WORD_W-1:0] e00, e11, e22, e01, e02, e10, e12, e20, e21;
  logic signed [AW-1:0]     a_sum;

  assign e00 = in_data.m00;
  assign e01 = in_data.m01;
  assign e02 = in_data.m02;
  assign e10 = in_data.m10;
  assign e11 = in_data.m11;
  assign e12 = in_data.m12;
  assign e20 = in_data.m20;
  assign e21 = in_data.m21;
  assign e22 = in_data.m22;

  // Handshake chain
  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Trace test, pivot choice and the three off-diagonal terms
  always_comb begin
    tr = ARG_W'(e00) + ARG_W'(e11) + ARG_W'(e22);
    if (tr > 0) begin
      sel1_nxt = SEL_TRACE;
      arg_nxt  = tr;
      d_nxt[0] = DIFF_W'(e12) - DIFF_W'(e21);
      d_nxt[1] = DIFF_W'(e20) - DIFF_W'(e02);
      d_nxt[2] = DIFF_W'(e01) - DIFF_W'(e10);
    end else if (e22 > e00 && e22 > e11) begin
      sel1_nxt = SEL_Z;
      arg_nxt  = ARG_W'(e22) - (ARG_W'(e00) + ARG_W'(e11));
      d_nxt[0] = DIFF_W'(e01) - DIFF_W'(e10);
      d_nxt[1] = DIFF_W'(e20) + DIFF_W'(e02);
      d_nxt[2] = DIFF_W'(e21) + DIFF_W'(e12);
    end else if (e11 > e00) begin
      sel1_nxt = SEL_Y;
      arg_nxt  = ARG_W'(e11) - (ARG_W'(e22) + ARG_W'(e00));
      d_nxt[0] = DIFF_W'(e20) - DIFF_W'(e02);
      d_nxt[1] = DIFF_W'(e12) + DIFF_W'(e21);
      d_nxt[2] = DIFF_W'(e10) + DIFF_W'(e01);
    end else begin
      sel1_nxt = SEL_X;
      arg_nxt  = ARG_W'(e00) - (ARG_W'(e11) + ARG_W'(e22));
      d_nxt[0] = DIFF_W'(e12) - DIFF_W'(e21);
      d_nxt[1] = DIFF_W'(e01) + DIFF_W'(e10);
      d_nxt[2] = DIFF_W'(e02) + DIFF_W'(e20);
    end
  end

  // Radicand (arg + ONE) * ONE, clamped at zero; magnitudes and signs
  always_comb begin
    a_sum = AW'(arg_r) + ONE_A;
    if (a_sum > 0) begin
      rad_nxt = {a_sum[AW-2:0], {F{1'b0}}};
    end else begin
      rad_nxt = '0;
    end
    for (int l = 0; l < 3; l++) begin
      sgn_nxt[l] = d_r[l][DIFF_W-1];
      mag_nxt[l] = sgn_nxt[l] ? DIFF_W'(-d_r[l]) : DIFF_W'(d_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      arg_r  <= arg_nxt;
      d_r    <= d_nxt;
      sel1_r <= sel1_nxt;
    end
    if (rdy2) begin
      rad_r  <= rad_nxt;
      mag_r  <= mag_nxt;
      sgn_r  <= sgn_nxt;
      sel2_r <= sel1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_rad   = rad_r;
  assign out_mag   = mag_r;
  assign out_sgn   = sgn_r;
  assign out_sel   = sel2_r;

endmodule

`default_nettype wire

>>> src/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined floor square root, one result bit per stage, with a sideband
// that travels alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt #(
  parameter int NW = 32,
  parameter int RW = 16,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [NW-1:0] in_rad,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [RW-1:0]      out_root,
  output logic [SW-1:0]      out_side
);

  localparam int XW = 2 * RW;

  logic [RW-1:0]   v_r;
  logic [RW:0]     rdy;
  logic [XW-1:0]   x_r    [RW];
  logic [RW+1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SW-1:0]   side_r [RW];

  assign rdy[RW] = out_ready;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic            v_in;
    logic [XW-1:0]   x_in;
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   root_in;
    logic [SW-1:0]   side_in;
    logic [RW+2:0]   rem2;
    logic [RW+2:0]   trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = XW'(in_rad);
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign x_in    = x_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign side_in = side_r[s-1];
    end

    // Bring down two radicand bits, try root*4+1
    assign rem2   = {rem_in[RW:0], x_in[XW-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem2 >= trial);
    assign rdy[s] = !v_r[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        x_r[s]    <= {x_in[XW-3:0], 2'b00};
        rem_r[s]  <= ge ? (RW+2)'(rem2 - trial) : (RW+2)'(rem2);
        root_r[s] <= {root_in[RW-2:0], ge};
        side_r[s] <= side_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

`default_nettype wire

>>> src/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div #(
  parameter int DW = 31,
  parameter int VW = 17,
  parameter int SW = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0][DW-1:0]   in_dvd,
  input  wire logic [VW-1:0]        in_dvs,
  input  wire logic [SW-1:0]        in_side,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0][DW-1:0]        out_quo,
  output logic [SW-1:0]             out_side
);

  logic [DW-1:0]          v_r;
  logic [DW:0]            rdy;
  logic [2:0][DW-1:0]     dq_r   [DW];
  logic [2:0][VW:0]       rem_r  [DW];
  logic [VW-1:0]          dvs_r  [DW];
  logic [SW-1:0]          side_r [DW];

  assign rdy[DW] = out_ready;

  for (genvar s = 0; s < DW; s++) begin : g_stage
    logic               v_in;
    logic [2:0][DW-1:0] dq_in;
    logic [2:0][VW:0]   rem_in;
    logic [VW-1:0]      dvs_in;
    logic [SW-1:0]      side_in;
    logic [2:0][DW-1:0] dq_nxt;
    logic [2:0][VW:0]   rem_nxt;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign dq_in   = in_dvd;
      assign rem_in  = '0;
      assign dvs_in  = in_dvs;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign dq_in   = dq_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign dvs_in  = dvs_r[s-1];
      assign side_in = side_r[s-1];
    end

    // Shift in the next dividend bit, subtract when it fits
    always_comb begin
      logic [VW:0] rem2;
      logic        ge;
      for (int l = 0; l < 3; l++) begin
        rem2       = {rem_in[l][VW-1:0], dq_in[l][DW-1]};
        ge         = (rem2 >= {1'b0, dvs_in});
        rem_nxt[l] = ge ? (rem2 - {1'b0, dvs_in}) : rem2;
        dq_nxt[l]  = {dq_in[l][DW-2:0], ge};
      end
    end

    assign rdy[s] = !v_r[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        dq_r[s]   <= dq_nxt;
        rem_r[s]  <= rem_nxt;
        dvs_r[s]  <= dvs_in;
        side_r[s] <= side_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[DW-1];
  assign out_quo   = dq_r[DW-1];
  assign out_side  = side_r[DW-1];

endmodule

`default_nettype wire

>>> src/rotation_matrix_to_quaternion.sv
// Path: front end, root pipeline, divider pipeline, output register; RW = root
//   width (16 at FRAC_BITS = 14) and DW = 17 + FRAC_BITS (31) = quotient width.
// Throughput: one conversion per cycle while out_ready holds; the bit-per-stage
//   root and divider pipelines are fully registered and stall stage by stage.
// Reset: synchronous active-low rst_n clears every valid bit; data is not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a fixed-point rotation matrix to a unit quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data
);

  localparam int F    = FRAC_BITS;
  localparam int AW   = ((F + 1 > ARG_W) ? F + 1 : ARG_W) + 1;
  localparam int NW   = AW - 1 + F;
  localparam int RW   = (NW + 1) / 2;
  localparam int VW   = RW + 1;
  localparam int DW   = DIFF_W + F;
  localparam int SW1  = 2 + 3 + 3 * DIFF_W;
  localparam int SW2  = 2 + 3 + RW;
  localparam int SATW = F + 2;

  localparam logic [DW-1:0] ONE_Q = DW'(1) << F;
  localparam logic [RW-1:0] ONE_R = RW'(1) << F;

  // Front end
  logic                   fr_valid, fr_ready;
  logic [NW-1:0]          fr_rad;
  logic [2:0][DIFF_W-1:0] fr_mag;
  logic [2:0]             fr_sgn;
  sel_t                   fr_sel;

  rmq_front #(.F(F), .AW(AW), .NW(NW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_rad   (fr_rad),
    .out_mag   (fr_mag),
    .out_sgn   (fr_sgn),
    .out_sel   (fr_sel)
  );

  // Square root
  logic            sq_valid, sq_ready;
  logic [RW-1:0]   sq_root;
  logic [SW1-1:0]  sq_side;

  rmq_sqrt #(.NW(NW), .RW(RW), .SW(SW1)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_rad    (fr_rad),
    .in_side   ({fr_sel, fr_sgn, fr_mag}),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Divide each term by twice the root
  logic [2:0][DIFF_W-1:0] sq_mag;
  logic [2:0][DW-1:0]     dv_dvd;
  logic                   dv_valid, dv_ready;
  logic [2:0][DW-1:0]     dv_quo;
  logic [SW2-1:0]         dv_side;

  assign sq_mag = sq_side[3*DIFF_W-1:0];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dv_dvd[l] = {sq_mag[l], {F{1'b0}}};
    end
  end

  rmq_div #(.DW(DW), .VW(VW), .SW(SW2)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_dvd    (dv_dvd),
    .in_dvs    ({sq_root, 1'b0}),
    .in_side   ({sq_side[SW1-1 -: 5], sq_root}),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // Saturate, sign and route components
  sel_t                    f_sel;
  logic [2:0]              f_sgn;
  logic [RW-1:0]           f_root;
  logic [RW-1:0]           f_half;
  logic [F:0]              f_cl [3];
  logic signed [SATW-1:0]  f_lane [3];
  logic signed [SATW-1:0]  f_piv;
  out_item_t               out_data_r, out_data_nxt;
  logic                    out_valid_r;

  assign f_sel    = sel_t'(dv_side[SW2-1 -: 2]);
  assign f_sgn    = dv_side[RW+2:RW];
  assign f_root   = dv_side[RW-1:0];
  assign f_half   = f_root >> 1;
  assign dv_ready = !out_valid_r || out_ready;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (f_root == '0) begin
        f_cl[l] = '0;
      end else if (dv_quo[l] > ONE_Q) begin
        f_cl[l] = ONE_Q[F:0];
      end else begin
        f_cl[l] = dv_quo[l][F:0];
      end
      f_lane[l] = f_sgn[l] ? -SATW'(f_cl[l]) : SATW'(f_cl[l]);
    end
    f_piv = (f_half > ONE_R) ? SATW'(ONE_R[F:0]) : SATW'(f_half[F:0]);
  end

  always_comb begin
    case (f_sel)
      SEL_TRACE: begin
        out_data_nxt.qx = WORD_W'(f_lane[0]);
        out_data_nxt.qy = WORD_W'(f_lane[1]);
        out_data_nxt.qz = WORD_W'(f_lane[2]);
        out_data_nxt.qw = WORD_W'(f_piv);
      end
      SEL_X: begin
        out_data_nxt.qx = WORD_W'(f_piv);
        out_data_nxt.qy = WORD_W'(f_lane[1]);
        out_data_nxt.qz = WORD_W'(f_lane[2]);
        out_data_nxt.qw = WORD_W'(f_lane[0]);
      end
      SEL_Y: begin
        out_data_nxt.qx = WORD_W'(f_lane[2]);
        out_data_nxt.qy = WORD_W'(f_piv);
        out_data_nxt.qz = WORD_W'(f_lane[1]);
        out_data_nxt.qw = WORD_W'(f_lane[0]);
      end
      default: begin
        out_data_nxt.qx = WORD_W'(f_lane[1]);
        out_data_nxt.qy = WORD_W'(f_lane[2]);
        out_data_nxt.qz = WORD_W'(f_piv);
        out_data_nxt.qw = WORD_W'(f_lane[0]);
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dv_ready) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input back-pressure only when the result is held by the sink
  a_ready_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  // Nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // Divider output feeds the output register whenever it is free
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid && (!out_valid || out_ready)) |=> out_valid)
    else $error("finished result not captured");

endmodule

`default_nettype wire
